[design/rdu_pkg.sv]
// rdu_pkg: shared constants for the restoring unsigned divider.
// No dependencies; imported by the step cell and the top level.
package rdu_pkg;

  localparam int unsigned WIDTH_MIN = 2;
  localparam int unsigned WIDTH_MAX = 32;

endpackage

[design/rdu_cell.sv]
// rdu_cell: one restoring bit-step with its own pipeline register.
// Depends on rdu_pkg.
module rdu_cell import rdu_pkg::*; #(
  parameter int unsigned WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_ready,
  input  logic [WIDTH-1:0] up_part,
  input  logic [WIDTH-1:0] up_num,
  input  logic [WIDTH-1:0] up_den,
  input  logic [WIDTH-1:0] up_quo,
  output logic             dn_valid,
  input  logic             dn_ready,
  output logic [WIDTH-1:0] dn_part,
  output logic [WIDTH-1:0] dn_num,
  output logic [WIDTH-1:0] dn_den,
  output logic [WIDTH-1:0] dn_quo
);

  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;
  logic             ge;
  logic [WIDTH-1:0] part_next;
  logic [WIDTH-1:0] quo_next;
  logic [WIDTH-1:0] num_next;

  always_comb begin
    shifted   = {up_part, up_num[WIDTH-1]};
    ge        = (shifted >= {1'b0, up_den});
    diff      = shifted - {1'b0, up_den};
    part_next = ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
    quo_next  = {up_quo[WIDTH-2:0], ge};
    num_next  = {up_num[WIDTH-2:0], 1'b0};
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_part <= part_next;
      dn_num  <= num_next;
      dn_den  <= up_den;
      dn_quo  <= quo_next;
    end
  end

  // partial remainder stays below a nonzero divisor
  a_part_below_den: assert property (@(posedge clk) disable iff (rst)
    dn_valid && (dn_den != '0) |-> (dn_part < dn_den))
    else $error("rdu_cell: partial remainder not below divisor");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    up_valid && up_ready |=> dn_valid)
    else $error("rdu_cell: accepted request lost");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    dn_valid && !dn_ready |=> dn_valid && $stable(dn_part) && $stable(dn_quo))
    else $error("rdu_cell: stalled step changed");

endmodule

[design/restoring_unsigned_divider.sv]
// restoring_unsigned_divider: chain of WIDTH restoring bit-step cells.
// Each cell resolves one quotient bit and registers it, one cell per bit.
// Throughput: one request per cycle while res_ready is high; each cell drains independently on stall.
// Reset (rst, synchronous): clears the valid bit of every cell, data not reset.
// Depends on rdu_pkg and rdu_cell.
module restoring_unsigned_divider import rdu_pkg::*; #(
  parameter int unsigned WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             res_valid,
  input  logic             res_ready,
  output logic [WIDTH-1:0] quotient_out,
  output logic [WIDTH-1:0] remainder_out
);

  logic             valid [WIDTH+1];
  logic             ready [WIDTH+1];
  logic [WIDTH-1:0] part  [WIDTH+1];
  logic [WIDTH-1:0] num   [WIDTH+1];
  logic [WIDTH-1:0] den   [WIDTH+1];
  logic [WIDTH-1:0] quo   [WIDTH+1];

  assign valid[0] = req_valid;
  assign req_ready = ready[0];
  assign part[0]  = '0;
  assign num[0]   = dividend;
  assign den[0]   = divisor;
  assign quo[0]   = '0;

  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    rdu_cell #(.WIDTH(WIDTH)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (valid[i]),
      .up_ready (ready[i]),
      .up_part  (part[i]),
      .up_num   (num[i]),
      .up_den   (den[i]),
      .up_quo   (quo[i]),
      .dn_valid (valid[i+1]),
      .dn_ready (ready[i+1]),
      .dn_part  (part[i+1]),
      .dn_num   (num[i+1]),
      .dn_den   (den[i+1]),
      .dn_quo   (quo[i+1])
    );
  end

  assign ready[WIDTH]  = res_ready;
  assign res_valid     = valid[WIDTH];
  assign quotient_out  = quo[WIDTH];
  assign remainder_out = part[WIDTH];

  a_width_range: assert property (@(posedge clk)
    (WIDTH >= WIDTH_MIN) && (WIDTH <= WIDTH_MAX))
    else $error("restoring_unsigned_divider: WIDTH out of range");

  a_zero_div: assert property (@(posedge clk) disable iff (rst)
    res_valid && (den[WIDTH] == '0) |-> (quotient_out == '1))
    else $error("restoring_unsigned_divider: zero divisor quotient not all ones");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    res_ready |-> ready[0])
    else $error("restoring_unsigned_divider: request blocked with open sink");

endmodule

[tb/sv/restoring_unsigned_divider_tb.sv]
// restoring_unsigned_divider_tb: self-checking bench for the restoring divider.
// Random gaps and stalls on both channels, checked against a bit-step divide.
// Depends on restoring_unsigned_divider and rdu_pkg.
module restoring_unsigned_divider_tb;

  localparam int unsigned WIDTH       = 16;
  localparam int          RAND_ITEMS  = 400;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          LONG_HOLD   = 150 + WIDTH;

  typedef struct packed {
    logic [WIDTH-1:0] dividend;
    logic [WIDTH-1:0] divisor;
  } div_request_t;

  typedef struct packed {
    logic [WIDTH-1:0] quotient;
    logic [WIDTH-1:0] remainder;
  } quot_rem_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_ready;
  logic [WIDTH-1:0] dividend = '0;
  logic [WIDTH-1:0] divisor = '0;
  logic             res_valid;
  logic             res_ready = 1'b0;
  logic [WIDTH-1:0] quotient_out;
  logic [WIDTH-1:0] remainder_out;

  div_request_t pending_divisions[$];
  quot_rem_t    expected_quot_rem[$];
  int           total_requests = 0;
  int           accepted_requests = 0;
  int           failures = 0;
  int           cycles = 0;
  int           hold_left = 0;

  restoring_unsigned_divider #(.WIDTH(WIDTH)) i_dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .dividend     (dividend),
    .divisor      (divisor),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .quotient_out (quotient_out),
    .remainder_out(remainder_out)
  );

  function automatic quot_rem_t restoring_divide(logic [WIDTH-1:0] num, logic [WIDTH-1:0] den);
    logic [WIDTH:0]   part;
    logic [WIDTH-1:0] quo;
    quot_rem_t        res;
    part = '0;
    quo  = '0;
    for (int b = WIDTH - 1; b >= 0; b--) begin
      part = {part[WIDTH-1:0], num[b]};
      quo  = quo << 1;
      if (part >= {1'b0, den}) begin
        part   = part - {1'b0, den};
        quo[0] = 1'b1;
      end
    end
    res.quotient  = quo;
    res.remainder = part[WIDTH-1:0];
    return res;
  endfunction

  // mostly short gaps, a few long ones, and calm stretches with none
  function automatic int idle_len(ref int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic div_request_t random_request();
    div_request_t rq;
    logic [31:0]  a;
    logic [31:0]  b;
    a = $urandom();
    b = $urandom();
    rq.dividend = a[WIDTH-1:0];
    rq.divisor  = b[WIDTH-1:0];
    case ($urandom_range(0, 9))
      0: rq.divisor = '0;
      1: rq.divisor = WIDTH'($urandom_range(1, 15));
      2: rq.dividend = rq.divisor == 0 ? '0 : WIDTH'($urandom_range(0, rq.divisor - 1));
      3: rq.divisor = rq.dividend;
      4: rq.dividend = WIDTH'($urandom_range(0, 255));
      5: rq.divisor = WIDTH'(1) << $urandom_range(0, WIDTH - 1);
      default: ;
    endcase
    return rq;
  endfunction

  task automatic add_request(logic [WIDTH-1:0] num, logic [WIDTH-1:0] den);
    div_request_t rq;
    rq.dividend = num;
    rq.divisor  = den;
    pending_divisions.push_back(rq);
    total_requests++;
  endtask

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    failures++;
  endtask

  initial begin
    forever #1 clk = ~clk;
  end

  // driver
  int tx_gap  = 0;
  int tx_calm = 0;
  always @(posedge clk) begin
    div_request_t rq;
    logic         holding;
    if (rst) begin
      req_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      holding = req_valid;
      if (req_valid && req_ready) begin
        expected_quot_rem.push_back(restoring_divide(dividend, divisor));
        accepted_requests++;
        holding = 1'b0;
      end
      if (!holding) begin
        if (tx_gap > 0) begin
          tx_gap--;
          req_valid <= 1'b0;
        end else if (pending_divisions.size() > 0) begin
          rq = pending_divisions.pop_front();
          req_valid <= 1'b1;
          dividend  <= rq.dividend;
          divisor   <= rq.divisor;
          tx_gap = idle_len(tx_calm);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, twice, so the pipeline fills and backs up
  int seen_requests = 0;
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else begin
      if (req_valid && req_ready) seen_requests++;
      if (hold_left > 0) hold_left <= hold_left - 1;
      else if (seen_requests == 60 || seen_requests == 260) hold_left <= LONG_HOLD;
    end
  end

  // monitor
  int rx_stall = 0;
  int rx_calm  = 0;
  always @(posedge clk) begin
    quot_rem_t want;
    if (rst) begin
      res_ready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (res_valid && res_ready) begin
        if (expected_quot_rem.size() == 0) begin
          report_mismatch($sformatf("unexpected result q=%h r=%h", quotient_out, remainder_out));
        end else begin
          want = expected_quot_rem.pop_front();
          if (quotient_out !== want.quotient)
            report_mismatch($sformatf("quotient %h, expected %h", quotient_out, want.quotient));
          if (remainder_out !== want.remainder)
            report_mismatch($sformatf("remainder %h, expected %h", remainder_out, want.remainder));
        end
      end
      if (hold_left > 0) begin
        res_ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
        if ($urandom_range(0, 5) == 0) rx_stall = idle_len(rx_calm);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    add_request('0, '0);
    add_request('1, '0);
    add_request(16'h1234, '0);
    add_request('0, '1);
    add_request('1, '1);
    add_request('1, 1);
    add_request(1, '1);
    add_request(0, 1);
    add_request(1, 1);
    add_request(16'h8000, 1);
    add_request('1, 2);
    add_request(16'h7fff, 16'h8000);
    add_request(16'h8000, 16'h7fff);
    add_request('1, 16'h8000);
    add_request(16'hfffe, '1);
    add_request(16'haaaa, 16'h5555);
    add_request(16'h5555, 16'haaaa);
    add_request(16'h0100, 16'h0010);
    add_request(16'hc350, 16'h0007);
    add_request(16'h0003, 16'h0007);
    for (int i = 0; i < RAND_ITEMS; i++) pending_divisions.push_back(random_request());
    total_requests += RAND_ITEMS;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (accepted_requests < total_requests || expected_quot_rem.size() > 0) @(posedge clk);
    repeat (2 * WIDTH + 8) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
